/* design/atpf_pkg.sv */
// Shared types and constants for the affine tile-map pixel fetch block.
package atpf_pkg;

    typedef enum logic [1:0] {
        REQ_RENDER = 2'd0,
        REQ_MAP    = 2'd1,
        REQ_PIX    = 2'd2,
        REQ_KEY    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        CFG_MAP_COLS  = 3'd0,
        CFG_MAP_ROWS  = 3'd1,
        CFG_TW_SHIFT  = 3'd2,
        CFG_TH_SHIFT  = 3'd3
    } t_cfg_idx;

    // fields of a request that travel down the pipe
    typedef struct packed {
        t_req        req;
        logic [11:0] cell_index;
        logic [7:0]  tile_id;
        logic        tile_present;
        logic [5:0]  pixel_offset;
        logic [7:0]  pixel_value;
        logic        key_enable;
    } t_item;

    // wrap-modulo state: partial remainders and the in-tile low bits
    typedef struct packed {
        logic [21:0] rx;
        logic [21:0] ry;
        logic [2:0]  lox;
        logic [2:0]  loy;
    } t_dv;

    localparam int FRAC_BITS   = 16;
    localparam int DIV_BITS    = 16;
    localparam int DIV_STAGES  = 4;
    localparam int DIV_PER_STG = 4;
    localparam int MAP_DIM_MAX = 64;

endpackage

/* design/affine_tilemap_pixel_fetch_core.sv */
// Affine (rotate/zoom) tile-map background pixel fetch, top level.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------
//  request | in        | start & !busy             | i_req_type .. i_key_enable
//  result  | out       | o_done (one-cycle strobe) | o_out_pixel, o_drawn
//  config  | in        | i_cfg_valid & o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One transaction per cycle while busy is low; every request gives its result in
//  the stage-9 result register. The throughput is set by the single port of each
//  memory, which every request touches once at a fixed stage (map store at stage 6,
//  tile stores at 7). After reset, busy stays high while a sweep over max(MAP_CELLS,
//  TILE_COUNT) addresses (4096 at the defaults) empties the map store and disables
//  every tile key. The result side cannot stall, so the pipe never stops.
module affine_tilemap_pixel_fetch_core
    import atpf_pkg::*;
#(
    parameter int MAP_CELLS      = 4096,
    parameter int TILE_COUNT     = 256,
    parameter int TILE_SHIFT_MAX = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_delta_x,
    input  logic signed [31:0] i_delta_y,
    input  logic [9:0]  i_screen_x,
    input  logic [11:0] i_cell_index,
    input  logic [7:0]  i_tile_id,
    input  logic        i_tile_present,
    input  logic [5:0]  i_pixel_offset,
    input  logic [7:0]  i_pixel_value,
    input  logic        i_key_enable,
    output logic        o_done,
    output logic [7:0]  o_out_pixel,
    output logic        o_drawn,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int MAP_AW  = $clog2(MAP_CELLS);
    localparam int TILE_AW = $clog2(TILE_COUNT);
    localparam int SLOT_W  = (2 * TILE_SHIFT_MAX > 0) ? 2 * TILE_SHIFT_MAX : 1;
    localparam int SLOT    = 1 << (2 * TILE_SHIFT_MAX);
    localparam int PIX_D   = TILE_COUNT << SLOT_W;
    localparam int CLR_N   = (MAP_CELLS > TILE_COUNT) ? MAP_CELLS : TILE_COUNT;
    localparam int CLR_W   = $clog2(CLR_N);

    // ---------------- configuration (held as effective, clamped values)
    logic [6:0] r_cols, r_rows;
    logic [1:0] r_tws, r_ths;

    function automatic logic [6:0] clamp_dim(input logic [6:0] v);
        if (v == 7'd0) return 7'd1;
        if (v > 7'(MAP_DIM_MAX)) return 7'(MAP_DIM_MAX);
        return v;
    endfunction

    function automatic logic [1:0] clamp_sh(input logic [1:0] v);
        return (32'(v) > TILE_SHIFT_MAX) ? 2'(TILE_SHIFT_MAX) : v;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 7'(MAP_DIM_MAX);
            r_rows <= 7'(MAP_DIM_MAX);
            r_tws  <= clamp_sh(2'd3);
            r_ths  <= clamp_sh(2'd3);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAP_COLS: r_cols <= clamp_dim(i_cfg_data[6:0]);
                CFG_MAP_ROWS: r_rows <= clamp_dim(i_cfg_data[6:0]);
                CFG_TW_SHIFT: r_tws  <= clamp_sh(i_cfg_data[1:0]);
                CFG_TH_SHIFT: r_ths  <= clamp_sh(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // ---------------- post-reset clearing sweep
    logic             r_clearing;
    logic [CLR_W-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            if (32'(r_clr_cnt) == CLR_N - 1) r_clearing <= 1'b0;
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign busy = r_clearing;

    logic accept;
    assign accept = start && !r_clearing;

    // ---------------- pipe valid bits and per-stage request fields
    logic [9:1] r_vld;
    t_item      r_it [1:7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[8:1], accept};
    end

    always_ff @(posedge i_clk) begin
        r_it[1] <= '{req: t_req'(i_req_type), cell_index: i_cell_index,
                     tile_id: i_tile_id, tile_present: i_tile_present,
                     pixel_offset: i_pixel_offset, pixel_value: i_pixel_value,
                     key_enable: i_key_enable};
        for (int k = 2; k <= 7; k++) r_it[k] <= r_it[k-1];
    end

    // ---------------- stage 1: column products
    logic [31:0] r_sx1, r_sy1, r_px1, r_py1;
    logic [31:0] prod_x, prod_y;

    // only the low 32 bits matter: the sum wraps at 32 bits
    assign prod_x = i_delta_x * {22'd0, i_screen_x};
    assign prod_y = i_delta_y * {22'd0, i_screen_x};

    always_ff @(posedge i_clk) begin
        r_sx1 <= i_start_x;
        r_sy1 <= i_start_y;
        r_px1 <= prod_x;
        r_py1 <= prod_y;
    end

    // ---------------- stage 2: integer coordinate, split into tile column and in-tile bits
    // x mod (cols << tws) = ((x >>> tws) mod cols) << tws | low tws bits of x.
    // The tile part is offset by cols << 15 so that the modulo sees a positive value.
    logic [31:0]        u_x, u_y;
    logic signed [15:0] hi_x, hi_y, v_x, v_y;
    t_dv                r_dv [0:DIV_STAGES];
    t_dv                n_dv [1:DIV_STAGES];

    assign u_x  = r_sx1 + r_px1;
    assign u_y  = r_sy1 + r_py1;
    assign hi_x = signed'(u_x[31:FRAC_BITS]);
    assign hi_y = signed'(u_y[31:FRAC_BITS]);
    assign v_x  = hi_x >>> r_tws;
    assign v_y  = hi_y >>> r_ths;

    always_ff @(posedge i_clk) begin
        r_dv[0].rx  <= 22'(v_x) + {r_cols, 15'd0};
        r_dv[0].ry  <= 22'(v_y) + {r_rows, 15'd0};
        r_dv[0].lox <= u_x[FRAC_BITS+2:FRAC_BITS] & ~(3'b111 << r_tws);
        r_dv[0].loy <= u_y[FRAC_BITS+2:FRAC_BITS] & ~(3'b111 << r_ths);
        for (int s = 1; s <= DIV_STAGES; s++) r_dv[s] <= n_dv[s];
    end

    // ---------------- stages 3..6: restoring modulo, four bits per stage
    always_comb begin
        logic [21:0] rx, ry;
        int          b;
        for (int s = 1; s <= DIV_STAGES; s++) begin
            rx = r_dv[s-1].rx;
            ry = r_dv[s-1].ry;
            for (int j = 0; j < DIV_PER_STG; j++) begin
                b = DIV_BITS - 1 - (s - 1) * DIV_PER_STG - j;
                if (rx >= (22'(r_cols) << b)) rx = rx - (22'(r_cols) << b);
                if (ry >= (22'(r_rows) << b)) ry = ry - (22'(r_rows) << b);
            end
            n_dv[s]     = r_dv[s-1];
            n_dv[s].rx  = rx;
            n_dv[s].ry  = ry;
        end
    end

    // ---------------- stage 6 -> 7: map store access
    logic [8:0]        m_map [MAP_CELLS];
    logic [8:0]        r_map_q;
    logic [11:0]       idx;
    logic [13:0]       map_size;
    logic              map_wr_ok;
    logic              r_idx_ok7;
    logic [2:0]        r_px7, r_py7;

    // tile row and column are both below 64, so the index fits 12 bits
    assign idx       = 12'(r_dv[DIV_STAGES].ry[5:0]) * 12'(r_cols)
                     + 12'(r_dv[DIV_STAGES].rx[5:0]);
    assign map_size  = 14'(r_cols) * 14'(r_rows);
    assign map_wr_ok = (14'(r_it[6].cell_index) < map_size)
                    && (32'(r_it[6].cell_index) < MAP_CELLS);

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            if (32'(r_clr_cnt) < MAP_CELLS) m_map[MAP_AW'(r_clr_cnt)] <= '0;
        end else if (r_vld[6] && r_it[6].req == REQ_MAP && map_wr_ok) begin
            m_map[MAP_AW'(r_it[6].cell_index)] <=
                r_it[6].tile_present ? {1'b1, r_it[6].tile_id} : 9'd0;
        end else begin
            r_map_q <= m_map[MAP_AW'(idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_ok7 <= 32'(idx) < MAP_CELLS;
        r_px7     <= r_dv[DIV_STAGES].lox;
        r_py7     <= r_dv[DIV_STAGES].loy;
    end

    // ---------------- stage 7 -> 8: tile pixel and key stores
    logic [7:0]                m_pix [PIX_D];
    logic [8:0]                m_key [TILE_COUNT];
    logic [7:0]                r_pix_q;
    logic [8:0]                r_key_q;
    logic                      r_hit8;
    logic [5:0]                off6;
    logic                      hit7;
    logic                      tid_ok;
    logic [TILE_AW+SLOT_W-1:0] rd_addr, wr_addr;

    assign off6    = 6'({3'd0, r_py7} << r_tws) + 6'(r_px7);
    // bubbles never hit, so idle result ports stay at zero
    assign hit7    = r_vld[7] && (r_it[7].req == REQ_RENDER) && r_idx_ok7 && r_map_q[8]
                  && (32'(r_map_q[7:0]) < TILE_COUNT);
    assign tid_ok  = 32'(r_it[7].tile_id) < TILE_COUNT;
    assign rd_addr = {TILE_AW'(r_map_q[7:0]), SLOT_W'(32'(off6) & (SLOT - 1))};
    assign wr_addr = {TILE_AW'(r_it[7].tile_id),
                      SLOT_W'(32'(r_it[7].pixel_offset) & (SLOT - 1))};

    always_ff @(posedge i_clk) begin
        if (r_vld[7] && r_it[7].req == REQ_PIX && tid_ok) begin
            m_pix[wr_addr] <= r_it[7].pixel_value;
        end else begin
            r_pix_q <= m_pix[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            if (32'(r_clr_cnt) < TILE_COUNT) m_key[TILE_AW'(r_clr_cnt)] <= '0;
        end else if (r_vld[7] && r_it[7].req == REQ_KEY && tid_ok) begin
            m_key[TILE_AW'(r_it[7].tile_id)] <=
                r_it[7].key_enable ? {1'b1, r_it[7].pixel_value} : 9'd0;
        end else begin
            r_key_q <= m_key[TILE_AW'(r_map_q[7:0])];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit8  <= hit7;
    end

    // ---------------- stage 8 -> 9: result register
    logic [7:0] r_o_pixel;
    logic       r_o_drawn;

    always_ff @(posedge i_clk) begin
        r_o_pixel <= r_hit8 ? r_pix_q : 8'd0;
        r_o_drawn <= r_hit8 && !(r_key_q[8] && r_key_q[7:0] == r_pix_q);
    end

    assign o_done      = r_vld[9];
    assign o_out_pixel = r_o_pixel;
    assign o_drawn     = r_o_drawn;

endmodule

/* design/atpf_checker.sv */
// Port-level checker for the affine tile-map pixel fetch core, and its bind.
module atpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_drawn,
    input logic [7:0] o_out_pixel
);

    a_clear_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy not raised after reset");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##9 o_done)
        else $error("result missing nine cycles after request");

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result during clearing sweep");

    a_drawn_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_drawn || o_out_pixel != 8'd0) |-> o_done)
        else $error("result data without strobe");

endmodule

bind affine_tilemap_pixel_fetch_core atpf_checker u_atpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_drawn     (o_drawn),
    .o_out_pixel (o_out_pixel)
);
